### hdl/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
// No dependencies; imported by cartridge_bank_mapper.
package cbm_pkg;

    localparam int WINDOW_COUNT = 8;
    localparam int WINDOW_W     = 3;
    localparam int BANK_W       = 5;
    localparam int BANK_BYTES   = 8192;
    localparam int OFFSET_W     = 13;
    localparam int ADDR_W       = 16;
    localparam int DATA_W       = 8;
    localparam int LOAD_W       = 18;
    localparam int OP_W         = 2;
    localparam int IN_TDATA_W   = 48;
    localparam int PADDR_W      = 3;

    typedef logic [OP_W-1:0]   op_t;
    typedef logic [BANK_W-1:0] bank_t;

    localparam op_t OP_READ  = 2'd0;
    localparam op_t OP_WRITE = 2'd1;
    localparam op_t OP_LOAD  = 2'd2;

    localparam logic [PADDR_W-1:0] REG_BANKING_ENABLE = 3'd0;

    localparam bank_t BANK_RESET [WINDOW_COUNT] = '{
        5'd0, 5'd0, 5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd5
    };

endpackage

### hdl/cartridge_bank_mapper.sv
// Cartridge bank mapper: eight 8 KB window bank registers and a ROM image store.
// Depends on cbm_pkg.
// Result path: input register, then ROM read register.
// Throughput: one transfer per cycle; input stalls only while both stages hold data
// and m_tready is low.
// Reset (aresetn, synchronous, active low): pipeline emptied, banking enabled,
// bank registers 0,0,0,1,2,3,4,5. ROM contents are not cleared; no clearing pass.
module cartridge_bank_mapper #(
    parameter int BANK_COUNT = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // APB-style configuration port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cbm_pkg::PADDR_W-1:0]        paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    // input: operation[1:0], bus_address[17:2], bus_data[25:18], load_index[43:26], zeros
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [cbm_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result: read_data[7:0]
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [cbm_pkg::DATA_W-1:0]         m_tdata
);
    import cbm_pkg::*;

    localparam int BANK_IDX_W  = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
    localparam int STORE_BYTES = BANK_COUNT * BANK_BYTES;
    localparam int STORE_AW    = BANK_IDX_W + OFFSET_W;
    localparam int BANK_VALUES = 1 << BANK_W;
    localparam logic [LOAD_W:0] STORE_LIMIT = (LOAD_W+1)'(STORE_BYTES);

    // configuration
    logic banking_enable_reg;

    // input stage
    logic                  st_valid_reg;
    op_t                   st_op_reg;
    logic [ADDR_W-1:0]     st_addr_reg;
    logic [DATA_W-1:0]     st_data_reg;
    logic [LOAD_W-1:0]     st_lidx_reg;

    // result stage
    logic                  out_valid_reg;
    logic                  out_read_reg;
    logic [DATA_W-1:0]     rom_q_reg;

    bank_t                 bank_reg [WINDOW_COUNT];
    logic [DATA_W-1:0]     rom_mem [STORE_BYTES];

    logic                  adv;
    logic [WINDOW_W-1:0]   st_win;
    logic [OFFSET_W-1:0]   st_offset;
    logic                  bank_we;
    logic                  load_we;
    logic [BANK_IDX_W-1:0] bank_wrap [BANK_VALUES];
    logic [STORE_AW-1:0]   rd_addr;

    assign pready = 1'b1;
    assign prdata = (paddr == REG_BANKING_ENABLE) ? {31'd0, banking_enable_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            banking_enable_reg <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr == REG_BANKING_ENABLE) begin
            banking_enable_reg <= pwdata[0];
        end
    end

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = !st_valid_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else if (s_tready) begin
            st_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            st_op_reg   <= s_tdata[1:0];
            st_addr_reg <= s_tdata[17:2];
            st_data_reg <= s_tdata[25:18];
            st_lidx_reg <= s_tdata[43:26];
        end
    end

    assign st_win    = st_addr_reg[ADDR_W-1:OFFSET_W];
    assign st_offset = st_addr_reg[OFFSET_W-1:0];
    assign bank_we   = st_valid_reg && adv && st_op_reg == OP_WRITE && banking_enable_reg
                       && ((st_offset == '0 && st_win > 3'd2) || st_addr_reg[11:0] == 12'd0);
    assign load_we   = st_valid_reg && adv && st_op_reg == OP_LOAD
                       && {1'b0, st_lidx_reg} < STORE_LIMIT;

    // bank number wrapped into the store
    for (genvar g = 0; g < BANK_VALUES; g++) begin : g_bank_wrap
        assign bank_wrap[g] = BANK_IDX_W'(g % BANK_COUNT);
    end

    assign rd_addr = {bank_wrap[bank_reg[st_win]], st_offset};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int w = 0; w < WINDOW_COUNT; w++) begin
                bank_reg[w] <= BANK_RESET[w];
            end
        end else if (bank_we) begin
            bank_reg[st_win] <= st_data_reg[BANK_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (load_we) begin
            rom_mem[st_lidx_reg[STORE_AW-1:0]] <= st_data_reg;
        end
        if (adv) begin
            rom_q_reg <= rom_mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= st_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_read_reg <= st_op_reg == OP_READ;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_read_reg ? rom_q_reg : '0;

    a_disabled_banks_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !banking_enable_reg |-> !bank_we)
        else $error("bank register changed while banking disabled");

    a_low_windows_need_low12_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && st_op_reg == OP_WRITE && st_addr_reg[11:0] != 12'd0
         && st_win <= 3'd2) |-> !bank_we)
        else $error("bank switch on window 0..2 without low 12 bits clear");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (st_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled with room in the pipeline");

    a_item_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (st_valid_reg && adv) |=> m_tvalid)
        else $error("item lost between input and result stage");

endmodule
